// ----- rtl/lookup2_byte_stream_hash_top_assert.svh -----
// Assertion macros shared by the hash datapath.
`ifndef LOOKUP2_BYTE_STREAM_HASH_TOP_ASSERT_SVH
`define LOOKUP2_BYTE_STREAM_HASH_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define L2BSH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define L2BSH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define L2BSH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define L2BSH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/l2bsh_pkg.sv -----
`default_nettype none
package l2bsh_pkg;

    localparam logic [31:0] GOLDEN      = 32'h9e3779b9;
    localparam int          QUEUE_DEPTH = 4;
    localparam int          MIX_STEPS   = 9;
    localparam int          STEP_W      = $clog2(MIX_STEPS);

    typedef enum logic [1:0] {
        JOB_GROUP       = 2'd0,
        JOB_FINAL       = 2'd1,
        JOB_GROUP_FINAL = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [31:0] a_add;
        logic [31:0] b_add;
        logic [31:0] c_add;
        logic [31:0] len;
    } job_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } abc_t;

    // one of the nine mix steps
    function automatic abc_t mix_step(abc_t s, logic [STEP_W-1:0] step);
        abc_t r;
        r = s;
        unique case (step)
            4'd0:    r.a = (s.a - s.b - s.c) ^ (s.c >> 13);
            4'd1:    r.b = (s.b - s.c - s.a) ^ (s.a << 8);
            4'd2:    r.c = (s.c - s.a - s.b) ^ (s.b >> 13);
            4'd3:    r.a = (s.a - s.b - s.c) ^ (s.c >> 12);
            4'd4:    r.b = (s.b - s.c - s.a) ^ (s.a << 16);
            4'd5:    r.c = (s.c - s.a - s.b) ^ (s.b >> 5);
            4'd6:    r.a = (s.a - s.b - s.c) ^ (s.c >> 3);
            4'd7:    r.b = (s.b - s.c - s.a) ^ (s.a << 10);
            4'd8:    r.c = (s.c - s.a - s.b) ^ (s.b >> 15);
            default: r = s;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/l2bsh_byte_if.sv -----
`default_nettype none
interface l2bsh_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_of_key;

    modport source (output valid, data_byte, byte_present, last_of_key, input ready);
    modport sink   (input valid, data_byte, byte_present, last_of_key, output ready);
endinterface
`default_nettype wire

// ----- rtl/l2bsh_hash_if.sv -----
`default_nettype none
interface l2bsh_hash_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest;

    modport source (output valid, digest, input ready);
    modport sink   (input valid, digest, output ready);
endinterface
`default_nettype wire

// ----- rtl/l2bsh_front.sv -----
`default_nettype none
module l2bsh_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    l2bsh_byte_if.sink        key_bytes,
    input  wire logic         q_full,
    output l2bsh_pkg::job_t   job,
    output logic              push,
    output logic              empty
);

    logic [31:0] ga_reg,   ga_next;
    logic [31:0] gb_reg,   gb_next;
    logic [23:0] tail_reg, tail_next;
    logic [3:0]  pos_reg,  pos_next;
    logic [31:0] len_reg,  len_next;
    logic        accept;
    logic        group_done;

    assign key_bytes.ready = !q_full;
    assign accept          = key_bytes.valid && key_bytes.ready;
    assign empty           = (len_reg == 32'd0) && (pos_reg == 4'd0);

    always_comb
    begin
        ga_next    = ga_reg;
        gb_next    = gb_reg;
        tail_next  = tail_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        group_done = 1'b0;
        push       = 1'b0;
        job.kind   = l2bsh_pkg::JOB_GROUP;
        job.a_add  = ga_reg;
        job.b_add  = gb_reg;
        job.c_add  = {key_bytes.data_byte, tail_reg};
        job.len    = len_reg;
        if (accept)
        begin
            if (key_bytes.byte_present)
            begin
                len_next = len_reg + 32'd1;
                priority if (pos_reg < 4'd4)
                begin
                    ga_next[{pos_reg[1:0], 3'b000} +: 8] = key_bytes.data_byte;
                    pos_next = pos_reg + 4'd1;
                end
                else if (pos_reg < 4'd8)
                begin
                    gb_next[{pos_reg[1:0], 3'b000} +: 8] = key_bytes.data_byte;
                    pos_next = pos_reg + 4'd1;
                end
                else if (pos_reg < 4'd11)
                begin
                    tail_next[{pos_reg[1:0], 3'b000} +: 8] = key_bytes.data_byte;
                    pos_next = pos_reg + 4'd1;
                end
                else
                begin
                    group_done = 1'b1;
                end
            end
            job.len = len_next;
            if (key_bytes.last_of_key)
            begin
                push = 1'b1;
                if (group_done)
                begin
                    job.kind = l2bsh_pkg::JOB_GROUP_FINAL;
                end
                else
                begin
                    job.kind  = l2bsh_pkg::JOB_FINAL;
                    job.a_add = ga_next;
                    job.b_add = gb_next;
                    job.c_add = len_next + {tail_next, 8'h00};
                end
                len_next = 32'd0;
            end
            else if (group_done)
            begin
                push = 1'b1;
            end
            if (key_bytes.last_of_key || group_done)
            begin
                ga_next   = 32'd0;
                gb_next   = 32'd0;
                tail_next = 24'd0;
                pos_next  = 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ga_reg   <= 32'd0;
            gb_reg   <= 32'd0;
            tail_reg <= 24'd0;
            pos_reg  <= 4'd0;
            len_reg  <= 32'd0;
        end
        else
        begin
            ga_reg   <= ga_next;
            gb_reg   <= gb_next;
            tail_reg <= tail_next;
            pos_reg  <= pos_next;
            len_reg  <= len_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/l2bsh_queue.sv -----
`default_nettype none
`include "lookup2_byte_stream_hash_top_assert.svh"
module l2bsh_queue #(
    parameter int DEPTH = l2bsh_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire l2bsh_pkg::job_t  push_job,
    input  wire logic             pop,
    output l2bsh_pkg::job_t       head,
    output logic                  valid,
    output logic                  full
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    l2bsh_pkg::job_t  mem_reg [DEPTH];
    logic [PtrW-1:0]  wr_reg, wr_next;
    logic [PtrW-1:0]  rd_reg, rd_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;

    assign valid = (cnt_reg != '0);
    assign full  = (cnt_reg == CntW'(DEPTH));
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_reg + PtrW'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PtrW'(DEPTH - 1)) ? '0 : rd_reg + PtrW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CntW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    `L2BSH_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full, "push into full queue")
    `L2BSH_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, valid, "pop from empty queue")
    `L2BSH_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= CntW'(DEPTH), "count out of range")

endmodule
`default_nettype wire

// ----- rtl/l2bsh_back.sv -----
`default_nettype none
`include "lookup2_byte_stream_hash_top_assert.svh"
module l2bsh_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire l2bsh_pkg::job_t  q_job,
    output logic                  pop,
    input  wire logic             front_empty,
    input  wire logic             cfg_we,
    input  wire logic [31:0]      cfg_data,
    l2bsh_hash_if.source          hashes
);

    localparam logic [l2bsh_pkg::STEP_W-1:0] LastStep =
        l2bsh_pkg::STEP_W'(l2bsh_pkg::MIX_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MIX  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    l2bsh_pkg::abc_t               abc_reg, abc_next, stepped;
    logic [l2bsh_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                          phase_reg, phase_next;
    l2bsh_pkg::job_kind_t          kind_reg, kind_next;
    logic [31:0]                   len_reg, len_next;
    logic [31:0]                   init_reg, init_next;
    logic [31:0]                   hash_reg, hash_next;
    logic                          out_valid_reg, out_valid_next;

    assign hashes.valid  = out_valid_reg;
    assign hashes.digest = hash_reg;
    assign stepped       = l2bsh_pkg::mix_step(abc_reg, step_reg);

    always_comb
    begin
        state_next     = state_reg;
        abc_next       = abc_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        len_next       = len_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg;
        init_next      = init_reg;
        pop            = 1'b0;
        if (hashes.valid && hashes.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg_we)
        begin
            init_next = cfg_data;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    abc_next.a = abc_reg.a + q_job.a_add;
                    abc_next.b = abc_reg.b + q_job.b_add;
                    abc_next.c = abc_reg.c + q_job.c_add;
                    kind_next  = q_job.kind;
                    len_next   = q_job.len;
                    step_next  = '0;
                    phase_next = 1'b0;
                    state_next = ST_MIX;
                end
                else if (cfg_we && front_empty)
                begin
                    // key not started yet: new seed applies at once
                    abc_next.c = cfg_data;
                end
            end
            ST_MIX:
            begin
                abc_next = stepped;
                if (step_reg == LastStep)
                begin
                    step_next = '0;
                    if ((kind_reg == l2bsh_pkg::JOB_GROUP_FINAL) && !phase_reg)
                    begin
                        abc_next.c = stepped.c + len_reg;
                        phase_next = 1'b1;
                    end
                    else if (kind_reg == l2bsh_pkg::JOB_GROUP)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    step_next = step_reg + l2bsh_pkg::STEP_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || hashes.ready)
                begin
                    hash_next      = abc_reg.c;
                    out_valid_next = 1'b1;
                    abc_next.a     = l2bsh_pkg::GOLDEN;
                    abc_next.b     = l2bsh_pkg::GOLDEN;
                    abc_next.c     = init_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            abc_reg.a     <= l2bsh_pkg::GOLDEN;
            abc_reg.b     <= l2bsh_pkg::GOLDEN;
            abc_reg.c     <= 32'd0;
            step_reg      <= '0;
            phase_reg     <= 1'b0;
            init_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            abc_reg       <= abc_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        len_reg  <= len_next;
        hash_reg <= hash_next;
    end

    `L2BSH_ASSERT_IMP(a_step_range, clk, rst_n, state_reg == ST_MIX,
        step_reg <= LastStep, "mix step out of range")
    `L2BSH_ASSERT_IMP(a_phase_kind, clk, rst_n, phase_reg,
        kind_reg == l2bsh_pkg::JOB_GROUP_FINAL, "second pass on wrong transaction kind")
    `L2BSH_ASSERT_IMP(a_out_from_done, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg == ST_DONE), "hash issued outside final step")

endmodule
`default_nettype wire

// ----- rtl/lookup2_byte_stream_hash_top.sv -----
// Channel     Dir  Handshake     Payload
// key_bytes   in   valid/ready   data_byte[7:0], byte_present, last_of_key
// hashes      out  valid/ready   digest[31:0]
// cfg         in   cfg_we        cfg_data[31:0] (init_value)
//
// One byte transaction per cycle while the job queue has room.
// The back end mixes each 12-byte group and each key close (both in turn when the closing byte
// completes a group): one shared mix step per cycle.
// Reset (rst_n, async, active low) clears control state; no clearing pass.
// A stalled hash output holds the back end; input stalls only when the queue fills.
`default_nettype none
module lookup2_byte_stream_hash_top #(
    parameter int QUEUE_DEPTH = l2bsh_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    l2bsh_byte_if.sink       key_bytes,
    l2bsh_hash_if.source     hashes,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data
);

    l2bsh_pkg::job_t push_job;
    l2bsh_pkg::job_t head_job;
    logic            push;
    logic            pop;
    logic            q_valid;
    logic            q_full;
    logic            front_empty;

    l2bsh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_bytes (key_bytes),
        .q_full    (q_full),
        .job       (push_job),
        .push      (push),
        .empty     (front_empty)
    );

    l2bsh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head_job),
        .valid    (q_valid),
        .full     (q_full)
    );

    l2bsh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_job       (head_job),
        .pop         (pop),
        .front_empty (front_empty),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .hashes      (hashes)
    );

endmodule
`default_nettype wire

// ----- tb/sv/l2bsh_hash_predict.sv -----
module l2bsh_hash_predict (
    input  wire logic        clk,
    input  wire logic        rst_n,
    l2bsh_byte_if            key_bytes,
    l2bsh_hash_if            hashes,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data,
    output int               fail_count,
    output int               hashes_seen,
    output int               hashes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] seed;
    logic [31:0] acc_a;
    logic [31:0] acc_b;
    logic [31:0] acc_c;
    logic [31:0] nbytes;
    logic [3:0]  pos;
    logic [23:0] tail;
    logic [31:0] expected_hashes[$];
    int          fails;
    int          seen;

    function automatic logic [95:0] lookup2_mix(input logic [31:0] a, b, c);
        a = (a - b - c) ^ (c >> 13);
        b = (b - c - a) ^ (a << 8);
        c = (c - a - b) ^ (b >> 13);
        a = (a - b - c) ^ (c >> 12);
        b = (b - c - a) ^ (a << 16);
        c = (c - a - b) ^ (b >> 5);
        a = (a - b - c) ^ (c >> 3);
        b = (b - c - a) ^ (a << 10);
        c = (c - a - b) ^ (b >> 15);
        return {a, b, c};
    endfunction

    task automatic start_key();
        acc_a  = l2bsh_pkg::GOLDEN;
        acc_b  = l2bsh_pkg::GOLDEN;
        acc_c  = seed;
        nbytes = '0;
        pos    = '0;
        tail   = '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [31:0] want;
        logic [7:0]  d;
        if (!rst_n)
        begin
            seed = '0;
            start_key();
            expected_hashes.delete();
            fails = 0;
            seen  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                seed = cfg_data;
                // reload c only if the current key has not started
                if (nbytes == 0 && pos == 0)
                    acc_c = seed;
            end

            if (key_bytes.valid && key_bytes.ready)
            begin
                d = key_bytes.data_byte;
                if (key_bytes.byte_present)
                begin
                    if (pos < 4'd4)
                        acc_a += 32'(d) << {pos[1:0], 3'b000};
                    else if (pos < 4'd8)
                        acc_b += 32'(d) << {pos[1:0], 3'b000};
                    else if (pos < 4'd11)
                        tail |= 24'(d) << {pos[1:0], 3'b000};
                    else
                    begin
                        acc_c += {d, tail};
                        {acc_a, acc_b, acc_c} = lookup2_mix(acc_a, acc_b, acc_c);
                        tail = '0;
                    end
                    pos = (pos >= 4'd11) ? 4'd0 : pos + 4'd1;
                    nbytes += 32'd1;
                end
                if (key_bytes.last_of_key)
                begin
                    acc_c += nbytes + {tail, 8'h00};
                    {acc_a, acc_b, acc_c} = lookup2_mix(acc_a, acc_b, acc_c);
                    expected_hashes.push_back(acc_c);
                    start_key();
                end
            end

            if (hashes.valid && hashes.ready)
            begin
                seen++;
                if (expected_hashes.size() == 0)
                begin
                    $error("digest: none expected, actual %08h", hashes.digest);
                    fails++;
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    if (hashes.digest !== want)
                    begin
                        $error("digest mismatch: expected %08h, actual %08h",
                               want, hashes.digest);
                        fails++;
                    end
                end
            end
        end
        fail_count     <= fails;
        hashes_seen    <= seen;
        hashes_pending <= expected_hashes.size();
    end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 150;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;
    logic        gaps_on;
    int          byte_items;
    int          seeds_used;
    int          quiet;
    int          fail_count;
    int          hashes_seen;
    int          hashes_pending;

    l2bsh_byte_if key_bytes ();
    l2bsh_hash_if hashes ();

    lookup2_byte_stream_hash_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_bytes (key_bytes),
        .hashes    (hashes),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    l2bsh_hash_predict u_predict (
        .clk            (clk),
        .rst_n          (rst_n),
        .key_bytes      (key_bytes),
        .hashes         (hashes),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .hashes_seen    (hashes_seen),
        .hashes_pending (hashes_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        hashes.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            hashes.ready <= !(gaps_on && $urandom_range(99) < 28);
        end
    end

    // watchdog: cycles with no transaction on any port
    initial
    begin
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((key_bytes.valid && key_bytes.ready) || (hashes.valid && hashes.ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    task automatic send(input logic [7:0] d, input logic present, input logic last);
        while (gaps_on && $urandom_range(99) < 28)
        begin
            key_bytes.valid <= 1'b0;
            @(posedge clk);
        end
        key_bytes.valid        <= 1'b1;
        key_bytes.data_byte    <= d;
        key_bytes.byte_present <= present;
        key_bytes.last_of_key  <= last;
        do
            @(posedge clk);
        while (!key_bytes.ready);
        if (present || last)
            byte_items++;
    endtask

    task automatic drain();
        key_bytes.valid <= 1'b0;
        do
            @(posedge clk);
        while (hashes_pending != 0);
    endtask

    task automatic write_seed(input logic [31:0] v);
        drain();
        // group jobs give no result; let the back end go quiet
        repeat (SETTLE) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        seeds_used++;
    endtask

    task automatic send_key(input int len, input bit close_on_byte);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 5)
                send(8'($urandom_range(255)), 1'b0, 1'b0);
            send(8'($urandom_range(255)), 1'b1, close_on_byte && i == len - 1);
        end
        if (!close_on_byte || len == 0)
            send(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic random_keys(input int items);
        int start;
        start = byte_items;
        while (byte_items - start < items)
        begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(0, 26);
            send_key(len, bit'($urandom_range(1)));
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_data               = '0;
        gaps_on                = 1'b0;
        key_bytes.valid        = 1'b0;
        key_bytes.data_byte    = '0;
        key_bytes.byte_present = 1'b0;
        key_bytes.last_of_key  = 1'b0;
        byte_items             = 0;
        seeds_used             = 0;
        repeat (12) @(posedge clk);
        rst_n   <= 1'b1;
        gaps_on <= 1'b1;

        write_seed(32'h0000_0000);
        send(8'h5a, 1'b0, 1'b0);
        send(8'h00, 1'b0, 1'b1);
        send(8'hff, 1'b1, 1'b1);
        // closing byte completes a full group
        for (int i = 0; i < 12; i++)
            send(i[0] ? 8'hff : 8'h00, 1'b1, i == 11);

        write_seed(32'hffff_ffff);
        // tail bytes 8..10 held at the close
        for (int i = 0; i < 11; i++)
            send(i[0] ? 8'h00 : 8'hff, 1'b1, 1'b0);
        send(8'h00, 1'b0, 1'b1);

        write_seed($urandom);
        random_keys(450);

        // start value written mid-key: applies from the next key only
        for (int i = 0; i < 7; i++)
            send(8'($urandom_range(255)), 1'b1, 1'b0);
        write_seed($urandom);
        send_key(9, bit'($urandom_range(1)));

        write_seed(l2bsh_pkg::GOLDEN);
        gaps_on <= 1'b0;
        random_keys(450);

        write_seed(32'h0000_0000);
        gaps_on <= 1'b1;
        random_keys(500);

        drain();
        repeat (SETTLE) @(posedge clk);
        $display("Hashed %0d keys from %0d byte transactions under %0d start values,",
                 hashes_seen, byte_items, seeds_used);
        $display("with random stalls on both channels and one unthrottled stretch.");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/l2bsh_pkg.sv
rtl/l2bsh_byte_if.sv
rtl/l2bsh_hash_if.sv
rtl/l2bsh_front.sv
rtl/l2bsh_queue.sv
rtl/l2bsh_back.sv
rtl/lookup2_byte_stream_hash_top.sv
tb/sv/l2bsh_hash_predict.sv
tb/sv/tb.sv
